FILE: rtl/core/crld_pkg.sv
// ----------------------------------------------------------------------------
// crld_pkg
// Shared types and constants for the cluster run list decoder.
// ----------------------------------------------------------------------------
package crld_pkg;

	// Largest size nibble accepted in a run header
	localparam logic [3:0] MAX_FIELD_BYTES = 4'd8;

	// Command queue between front and back (depth must be a power of two)
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Parser phases
	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_LENGTH = 2'd1;
	localparam logic [1:0] PH_OFFSET = 2'd2;

	// End status codes
	localparam logic [2:0] ST_RUNNING     = 3'd0;
	localparam logic [2:0] ST_TERMINATOR  = 3'd1;
	localparam logic [2:0] ST_ZERO_LENGTH = 3'd2;
	localparam logic [2:0] ST_TRUNCATED   = 3'd3;
	localparam logic [2:0] ST_OVERSIZE    = 3'd4;

	// Which accumulator a byte goes to
	localparam logic [1:0] FLD_NONE   = 2'd0;
	localparam logic [1:0] FLD_LENGTH = 2'd1;
	localparam logic [1:0] FLD_OFFSET = 2'd2;

	// One classified byte, front to back
	typedef struct packed {
		logic [7:0] data;
		logic [1:0] fld;
		logic [2:0] idx;
		logic       run_done;   // last offset byte: add and emit the run
		logic [3:0] off_bytes;  // offset size of the current run
		logic       emit_end;   // list ends on this byte
		logic [2:0] status;
		logic       clear;      // final byte: return to reset state
	} crld_cmd_t;

	// Sign-extend a little-endian offset of n bytes (n in 1..8)
	function automatic logic [63:0] sext_offset(input logic [63:0] v, input logic [3:0] n);
		logic [63:0] res;
		logic [2:0]  top;
		logic        sign;
		top  = n[2:0] - 3'd1;
		sign = v[{top, 3'b111}];
		res  = v;
		if (n < 4'd8) begin
			for (int k = 0; k < 8; k++) begin
				if (4'(k) >= n) begin
					res[8*k +: 8] = {8{sign}};
				end
			end
		end
		return res;
	endfunction

endpackage

FILE: rtl/core/crld_front.sv
// ----------------------------------------------------------------------------
// crld_front
// Header parser: tracks run framing and turns each byte into a command.
// ----------------------------------------------------------------------------
module crld_front #(
	parameter logic [3:0] MAX_FIELD_BYTES = crld_pkg::MAX_FIELD_BYTES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  logic [7:0]           data_byte,
	input  logic                 final_byte,
	input  logic                 q_full,
	output logic                 push,
	output crld_pkg::crld_cmd_t  cmd
);

	logic [1:0] phase_q, phase_n;
	logic [3:0] ls_q, ls_n;
	logic [3:0] os_q, os_n;
	logic [2:0] idx_q, idx_n;
	logic       stopped_q, stopped_n;
	logic [3:0] nidx;
	logic       ending;

	assign byte_stall = q_full;
	assign push       = byte_valid && !q_full;
	assign nidx       = {1'b0, idx_q} + 4'd1;

	always_comb begin
		phase_n       = phase_q;
		ls_n          = ls_q;
		os_n          = os_q;
		idx_n         = idx_q;
		stopped_n     = stopped_q;
		ending        = 1'b0;
		cmd.data      = data_byte;
		cmd.fld       = crld_pkg::FLD_NONE;
		cmd.idx       = idx_q;
		cmd.run_done  = 1'b0;
		cmd.off_bytes = os_q;
		cmd.emit_end  = 1'b0;
		cmd.status    = crld_pkg::ST_RUNNING;
		cmd.clear     = final_byte;

		if (!stopped_q) begin
			case (phase_q)
				crld_pkg::PH_HEADER: begin
					if (data_byte == 8'd0) begin
						ending     = 1'b1;
						cmd.status = crld_pkg::ST_TERMINATOR;
					end else if (data_byte[3:0] == 4'd0) begin
						ending     = 1'b1;
						cmd.status = crld_pkg::ST_ZERO_LENGTH;
					end else if (data_byte[3:0] > MAX_FIELD_BYTES ||
						     data_byte[7:4] > MAX_FIELD_BYTES) begin
						ending     = 1'b1;
						cmd.status = crld_pkg::ST_OVERSIZE;
					end else if (final_byte) begin
						ending     = 1'b1;
						cmd.status = crld_pkg::ST_TRUNCATED;
					end else begin
						ls_n    = data_byte[3:0];
						os_n    = data_byte[7:4];
						idx_n   = 3'd0;
						phase_n = crld_pkg::PH_LENGTH;
					end
				end
				crld_pkg::PH_LENGTH: begin
					cmd.fld = crld_pkg::FLD_LENGTH;
					if (nidx >= ls_q) begin
						idx_n   = 3'd0;
						phase_n = (os_q == 4'd0) ? crld_pkg::PH_HEADER : crld_pkg::PH_OFFSET;
					end else begin
						idx_n = nidx[2:0];
					end
				end
				crld_pkg::PH_OFFSET: begin
					cmd.fld = crld_pkg::FLD_OFFSET;
					if (nidx >= os_q) begin
						cmd.run_done = 1'b1;
						idx_n        = 3'd0;
						phase_n      = crld_pkg::PH_HEADER;
					end else begin
						idx_n = nidx[2:0];
					end
				end
				default: begin
					phase_n = crld_pkg::PH_HEADER;
				end
			endcase

			// final byte inside a run field: clean end or truncation
			if (final_byte && phase_q != crld_pkg::PH_HEADER) begin
				ending = 1'b1;
				if (phase_n != crld_pkg::PH_HEADER) begin
					cmd.status = crld_pkg::ST_TRUNCATED;
				end else begin
					cmd.status = crld_pkg::ST_RUNNING;
				end
			end
			cmd.emit_end = ending;
		end

		if (final_byte) begin
			phase_n   = crld_pkg::PH_HEADER;
			ls_n      = 4'd0;
			os_n      = 4'd0;
			idx_n     = 3'd0;
			stopped_n = 1'b0;
		end else if (ending) begin
			stopped_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= crld_pkg::PH_HEADER;
			ls_q      <= 4'd0;
			os_q      <= 4'd0;
			idx_q     <= 3'd0;
			stopped_q <= 1'b0;
		end else if (push) begin
			phase_q   <= phase_n;
			ls_q      <= ls_n;
			os_q      <= os_n;
			idx_q     <= idx_n;
			stopped_q <= stopped_n;
		end
	end

endmodule

FILE: rtl/core/crld_queue.sv
// ----------------------------------------------------------------------------
// crld_queue
// Small FIFO of commands between the parser and the run builder.
// ----------------------------------------------------------------------------
module crld_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  crld_pkg::crld_cmd_t  wr_cmd,
	output logic                 full,
	input  logic                 rd_en,
	output logic                 rd_valid,
	output crld_pkg::crld_cmd_t  rd_cmd
);

	crld_pkg::crld_cmd_t               slot_q [crld_pkg::QUEUE_DEPTH];
	logic [crld_pkg::QPTR_W-1:0]       wptr_q, rptr_q;
	logic [crld_pkg::QCNT_W-1:0]       count_q;

	assign full     = (count_q == crld_pkg::QCNT_W'(crld_pkg::QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wptr_q] <= wr_cmd;
		end
	end

	// pointers wrap naturally, depth is a power of two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd_en) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/crld_back.sv
// ----------------------------------------------------------------------------
// crld_back
// Run builder: gathers length/offset bytes, adds the offset, drives results.
// ----------------------------------------------------------------------------
module crld_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  crld_pkg::crld_cmd_t  cmd,
	output logic                 cmd_pop,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic                 run_present,
	output logic signed [63:0]   run_start_cluster,
	output logic [63:0]          run_length,
	output logic                 list_end,
	output logic [2:0]           end_status
);

	logic [63:0] len_q;
	logic [63:0] off_q;
	logic [63:0] prev_q;
	logic [63:0] byte_sh;
	logic [63:0] off_full;
	logic [63:0] sum;
	logic        produce;
	logic        valid_q;
	logic        present_q;
	logic [63:0] start_q;
	logic [63:0] length_q;
	logic        end_q;
	logic [2:0]  status_q;

	assign cmd_pop  = cmd_valid && (!valid_q || !result_stall);
	assign produce  = cmd.run_done || cmd.emit_end;
	assign byte_sh  = {56'd0, cmd.data} << {cmd.idx, 3'b000};
	assign off_full = ((cmd.idx == 3'd0) ? 64'd0 : off_q) | byte_sh;
	assign sum      = prev_q + crld_pkg::sext_offset(off_full, cmd.off_bytes);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= 64'd0;
			valid_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				if (cmd.clear) begin
					prev_q <= 64'd0;
				end else if (cmd.run_done) begin
					prev_q <= sum;
				end
			end
			if (cmd_pop && produce) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			if (cmd.fld == crld_pkg::FLD_LENGTH) begin
				len_q <= ((cmd.idx == 3'd0) ? 64'd0 : len_q) | byte_sh;
			end
			if (cmd.fld == crld_pkg::FLD_OFFSET) begin
				off_q <= off_full;
			end
			if (produce) begin
				present_q <= cmd.run_done;
				start_q   <= cmd.run_done ? sum : 64'd0;
				length_q  <= cmd.run_done ? len_q : 64'd0;
				end_q     <= cmd.emit_end;
				status_q  <= cmd.emit_end ? cmd.status : crld_pkg::ST_RUNNING;
			end
		end
	end

	assign result_valid      = valid_q;
	assign run_present       = present_q;
	assign run_start_cluster = $signed(start_q);
	assign run_length        = length_q;
	assign list_end          = end_q;
	assign end_status        = status_q;

endmodule

FILE: rtl/core/cluster_run_list_decoder_top.sv
// ----------------------------------------------------------------------------
// cluster_run_list_decoder_top
// Streaming decoder of a cluster run list, one byte per item.
// ----------------------------------------------------------------------------
// Input channel: byte_valid / byte_stall carry data_byte and final_byte; an
//   item is taken at an edge with byte_valid high and byte_stall low.
//   final_byte marks the last byte of the attribute area.
// Output channel: result_valid / result_stall carry one result item: a run
//   (run_present, run_start_cluster, run_length), an end of list (list_end,
//   end_status), or both when a clean end falls on the last byte of a run.
//   Bytes that complete nothing yield no item.
// Throughput: one byte per clock while results are taken. While a result
//   waits, the four-entry command queue takes up to four more bytes, then
//   byte_stall stays high until the receiver takes the result.
// Path: the accepting edge writes the command queue; the run builder then
//   pops the command, does the 64-bit add and loads the output register,
//   which raises result_valid. A waiting result can hold the pop.
// Structure: the parser classifies bytes into the command queue; the run
//   builder drains it into the output register.
// Reset: arst_n clears parser phase, queue, previous cluster and output
//   valid. Any byte with final_byte likewise returns the decoder to that
//   state once it has been processed; after an error end, bytes are dropped
//   until the next final_byte.
// ----------------------------------------------------------------------------
module cluster_run_list_decoder_top #(
	parameter logic [3:0] MAX_FIELD_BYTES = crld_pkg::MAX_FIELD_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  logic [7:0]          data_byte,
	input  logic                final_byte,
	output logic                result_valid,
	input  logic                result_stall,
	output logic                run_present,
	output logic signed [63:0]  run_start_cluster,
	output logic [63:0]         run_length,
	output logic                list_end,
	output logic [2:0]          end_status
);

	crld_pkg::crld_cmd_t front_cmd;
	crld_pkg::crld_cmd_t back_cmd;
	logic                push;
	logic                q_full;
	logic                q_valid;
	logic                pop;

	// parser: framing of header, length and offset fields
	crld_front #(
		.MAX_FIELD_BYTES (MAX_FIELD_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.q_full     (q_full),
		.push       (push),
		.cmd        (front_cmd)
	);

	// decouples parser from the output side
	crld_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_cmd   (front_cmd),
		.full     (q_full),
		.rd_en    (pop),
		.rd_valid (q_valid),
		.rd_cmd   (back_cmd)
	);

	// accumulators, cluster add and output register
	crld_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd_valid         (q_valid),
		.cmd               (back_cmd),
		.cmd_pop           (pop),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.run_present       (run_present),
		.run_start_cluster (run_start_cluster),
		.run_length        (run_length),
		.list_end          (list_end),
		.end_status        (end_status)
	);

	// a running item never carries a nonzero status
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !list_end |-> end_status == crld_pkg::ST_RUNNING)
		else $error("end status set without list end");

	// an item with neither a run nor an end should never be produced
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> run_present || list_end)
		else $error("empty result item");

	// a run delivered together with a list end carries a clean end, never an error end
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && run_present && list_end |-> end_status == crld_pkg::ST_RUNNING)
		else $error("run delivered with error status");

	// an item without a run carries zero start and length
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !run_present |-> run_length == 64'd0 && run_start_cluster == 64'sd0)
		else $error("stale run fields");

endmodule

FILE: dv/cluster_run_list_decoder_top_test.sv
// ----------------------------------------------------------------------------
// cluster_run_list_decoder_top_test
// Self-checking bench for the streaming cluster run list decoder.
// ----------------------------------------------------------------------------
// A short directed table goes first: every end status, sparse and non-sparse
// runs, sign extension and 64-bit wrap of the offset, and a clean end on the
// last byte of a run. Random run lists follow. Most are well formed with
// random field bytes; the rest end early, carry bad headers or are noise. A
// byte-level decoder model inside the bench predicts each result item. The
// monitor compares every result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module cluster_run_list_decoder_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TARGET_BYTES = 800;    // bytes sent, directed rows included
	localparam int CYCLE_LIMIT  = 200000;

	// One result item as seen on the output ports
	typedef struct packed {
		logic        present;
		logic [63:0] start_cluster;
		logic [63:0] length;
		logic        list_end;
		logic [2:0]  status;
	} run_result_t;

	typedef enum bit {BY_MODEL, TYPED} check_mode_t;

	// One row of the directed table
	typedef struct packed {
		logic [7:0]  data;
		logic        fin;
		check_mode_t mode;
		run_result_t want;
	} byte_row_t;

	// One raw byte of a generated list
	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} list_byte_t;

	localparam run_result_t NO_RESULT = '0;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               byte_valid;
	logic               byte_stall;
	logic [7:0]         data_byte;
	logic               final_byte;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic               run_present;
	logic signed [63:0] run_start_cluster;
	logic [63:0]        run_length;
	logic               list_end;
	logic [2:0]         end_status;

	cluster_run_list_decoder_top dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.byte_valid        (byte_valid),
		.byte_stall        (byte_stall),
		.data_byte         (data_byte),
		.final_byte        (final_byte),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.run_present       (run_present),
		.run_start_cluster (run_start_cluster),
		.run_length        (run_length),
		.list_end          (list_end),
		.end_status        (end_status)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------------
	// Bookkeeping
	// ------------------------------------------------------------------------
	run_result_t awaited_results[$];    // predicted items, oldest first
	list_byte_t  list_bytes[$];         // generated list waiting to be sent
	int          sender_idle_pct;
	int          receiver_stall_pct;
	int          fail_count;
	int          cycle_count;
	int          decoded_bytes;         // bytes seen by a running decoder
	int          ignored_bytes;         // bytes dropped after an error end
	int          runs_seen;
	int          ends_seen[8];          // list ends by status

	// ------------------------------------------------------------------------
	// Decoder model state
	// ------------------------------------------------------------------------
	logic [1:0]  rl_phase;
	logic [3:0]  rl_len_bytes;
	logic [3:0]  rl_off_bytes;
	logic [3:0]  rl_field_idx;
	logic [63:0] rl_len_acc;
	logic [63:0] rl_off_acc;
	logic [63:0] rl_prev_cluster;
	bit          rl_stopped;

	function automatic void clear_decoder();
		rl_phase        = crld_pkg::PH_HEADER;
		rl_len_bytes    = '0;
		rl_off_bytes    = '0;
		rl_field_idx    = '0;
		rl_len_acc      = '0;
		rl_off_acc      = '0;
		rl_prev_cluster = '0;
		rl_stopped      = 1'b0;
	endfunction

	// Feeds one byte to the model; 'produced' says whether an item follows.
	task automatic decode_byte(input logic [7:0] b, input logic last,
		output bit produced, output run_result_t r);
		logic [3:0] ls;
		logic [3:0] os;
		logic [2:0] idx;
		logic [2:0] status;
		bit         ends;

		r        = NO_RESULT;
		produced = 1'b0;
		ends     = 1'b0;
		status   = crld_pkg::ST_RUNNING;
		ls       = b[3:0];
		os       = b[7:4];
		idx      = rl_field_idx[2:0];

		// stopped list: swallow everything up to the final byte
		if (rl_stopped) begin
			if (last)
				clear_decoder();
			return;
		end

		if (rl_phase == crld_pkg::PH_HEADER) begin
			if (b == 8'h00) begin
				ends = 1'b1; status = crld_pkg::ST_TERMINATOR;
			end else if (ls == 4'd0) begin
				ends = 1'b1; status = crld_pkg::ST_ZERO_LENGTH;
			end else if (ls > crld_pkg::MAX_FIELD_BYTES || os > crld_pkg::MAX_FIELD_BYTES) begin
				ends = 1'b1; status = crld_pkg::ST_OVERSIZE;
			end else if (last) begin
				ends = 1'b1; status = crld_pkg::ST_TRUNCATED;
			end else begin
				rl_len_bytes = ls;
				rl_off_bytes = os;
				rl_field_idx = '0;
				rl_len_acc   = '0;
				rl_off_acc   = '0;
				rl_phase     = crld_pkg::PH_LENGTH;
			end
			if (ends) begin
				r.list_end = 1'b1;
				r.status   = status;
				produced   = 1'b1;
				if (last)
					clear_decoder();
				else
					rl_stopped = 1'b1;
			end
			return;
		end

		if (rl_phase == crld_pkg::PH_LENGTH) begin
			rl_len_acc   |= 64'(b) << (8 * idx);
			rl_field_idx  = {1'b0, idx} + 4'd1;
			if (rl_field_idx >= rl_len_bytes) begin
				rl_field_idx = '0;
				rl_phase     = (rl_off_bytes == 4'd0) ? crld_pkg::PH_HEADER
					: crld_pkg::PH_OFFSET;
			end
		end else begin
			rl_off_acc   |= 64'(b) << (8 * idx);
			rl_field_idx  = {1'b0, idx} + 4'd1;
			if (rl_field_idx >= rl_off_bytes) begin
				// short offsets are signed: extend from their top bit
				if (rl_off_bytes < 4'd8 && rl_off_acc[8 * rl_off_bytes - 1])
					rl_off_acc |= ~64'd0 << (8 * rl_off_bytes);
				rl_prev_cluster  += rl_off_acc;
				r.present         = 1'b1;
				r.start_cluster   = rl_prev_cluster;
				r.length          = rl_len_acc;
				produced          = 1'b1;
				rl_field_idx      = '0;
				rl_phase          = crld_pkg::PH_HEADER;
			end
		end

		// final byte: clean end on a run boundary, else truncated
		if (last) begin
			r.list_end = 1'b1;
			r.status   = (rl_phase != crld_pkg::PH_HEADER) ? crld_pkg::ST_TRUNCATED
				: crld_pkg::ST_RUNNING;
			produced   = 1'b1;
			clear_decoder();
		end
	endtask

	// ------------------------------------------------------------------------
	// Directed table
	// ------------------------------------------------------------------------
	byte_row_t directed_rows[24] = '{
		// terminator straight after reset, then a final byte to restart
		'{8'h00, 1'b0, TYPED,    '{1'b0, 64'd0, 64'd0, 1'b1, crld_pkg::ST_TERMINATOR}},
		'{8'h11, 1'b1, BY_MODEL, NO_RESULT},
		// zero length size on the final byte
		'{8'h10, 1'b1, TYPED,    '{1'b0, 64'd0, 64'd0, 1'b1, crld_pkg::ST_ZERO_LENGTH}},
		// offset nibble too large, list stays stopped until a final byte
		'{8'h91, 1'b0, TYPED,    '{1'b0, 64'd0, 64'd0, 1'b1, crld_pkg::ST_OVERSIZE}},
		'{8'h00, 1'b1, BY_MODEL, NO_RESULT},
		// length nibble too large
		'{8'h19, 1'b1, TYPED,    '{1'b0, 64'd0, 64'd0, 1'b1, crld_pkg::ST_OVERSIZE}},
		// valid header, but it is the last byte
		'{8'h11, 1'b1, TYPED,    '{1'b0, 64'd0, 64'd0, 1'b1, crld_pkg::ST_TRUNCATED}},
		// one-byte offset 0x80 sign-extends to -128
		'{8'h11, 1'b0, BY_MODEL, NO_RESULT},
		'{8'hFF, 1'b0, BY_MODEL, NO_RESULT},
		'{8'h80, 1'b0, TYPED,
			'{1'b1, 64'hFFFF_FFFF_FFFF_FF80, 64'hFF, 1'b0, crld_pkg::ST_RUNNING}},
		// sparse run: no item, cluster unchanged
		'{8'h01, 1'b0, BY_MODEL, NO_RESULT},
		'{8'h05, 1'b0, BY_MODEL, NO_RESULT},
		// eight-byte offset, clean end on its last byte, start wraps
		'{8'h81, 1'b0, BY_MODEL, NO_RESULT},
		'{8'hFF, 1'b0, BY_MODEL, NO_RESULT},
		'{8'h00, 1'b0, BY_MODEL, NO_RESULT},
		'{8'h00, 1'b0, BY_MODEL, NO_RESULT},
		'{8'h00, 1'b0, BY_MODEL, NO_RESULT},
		'{8'h00, 1'b0, BY_MODEL, NO_RESULT},
		'{8'h00, 1'b0, BY_MODEL, NO_RESULT},
		'{8'h00, 1'b0, BY_MODEL, NO_RESULT},
		'{8'h00, 1'b0, BY_MODEL, NO_RESULT},
		'{8'h80, 1'b1, BY_MODEL, NO_RESULT},
		// final byte in the middle of a run
		'{8'h21, 1'b0, BY_MODEL, NO_RESULT},
		'{8'h05, 1'b1, BY_MODEL, NO_RESULT}
	};

	// ------------------------------------------------------------------------
	// Input side: one byte per call, random idle before it
	// ------------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] d, input logic f,
		input check_mode_t mode, input run_result_t typed_result);
		bit          produced;
		run_result_t predicted;

		while ($urandom_range(99) < sender_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte  <= d;
		final_byte <= f;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);

		// taken at this edge
		if (rl_stopped)
			ignored_bytes++;
		else
			decoded_bytes++;
		decode_byte(d, f, produced, predicted);
		if (mode == TYPED)
			awaited_results = {awaited_results, typed_result};
		else if (produced)
			awaited_results = {awaited_results, predicted};
	endtask

	// ------------------------------------------------------------------------
	// Random list generation
	// ------------------------------------------------------------------------
	function automatic logic [7:0] field_byte();
		case ($urandom_range(7))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h80;
			3:       return 8'h7F;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic int pick_size(input int lo);
		return ($urandom_range(3) == 0) ? $urandom_range(lo, 8) : $urandom_range(lo, 3);
	endfunction

	function automatic void push_byte(input logic [7:0] d, input logic f);
		list_bytes = {list_bytes, list_byte_t'{d, f}};
	endfunction

	// noise the decoder should drop, then the final byte that restarts it
	function automatic void close_list();
		repeat ($urandom_range(3))
			push_byte(8'($urandom), 1'b0);
		push_byte(8'($urandom), 1'b1);
	endfunction

	function automatic void build_list();
		int runs;
		int ls;
		int os;
		int need;
		int taken;
		logic [3:0] hi;
		logic [3:0] lo;

		runs = $urandom_range(0, 5);
		for (int i = 0; i < runs; i++) begin
			ls = pick_size(1);
			os = pick_size(0);
			push_byte({os[3:0], ls[3:0]}, 1'b0);
			repeat (ls + os)
				push_byte(field_byte(), 1'b0);
		end

		case ($urandom_range(9))
			0, 1, 2, 3: begin
				// clean end on the last byte of the last run; a final terminator if no runs
				if (list_bytes.size() == 0)
					push_byte(8'h00, 1'b1);
				else
					list_bytes[list_bytes.size() - 1].fin = 1'b1;
			end
			4, 5: begin
				push_byte(8'h00, 1'b0);
				close_list();
			end
			6: begin
				// final byte lands inside a run
				ls    = pick_size(1);
				os    = pick_size(0);
				need  = ls + os;
				taken = $urandom_range(0, need - 1);
				push_byte({os[3:0], ls[3:0]}, taken == 0);
				for (int k = 1; k <= taken; k++)
					push_byte(field_byte(), k == taken);
			end
			7: begin
				hi = 4'($urandom_range(1, 15));
				push_byte({hi, 4'h0}, 1'($urandom));
				if (!list_bytes[list_bytes.size() - 1].fin)
					close_list();
			end
			8: begin
				// at least one nibble above eight, length nibble nonzero
				hi = 4'($urandom);
				lo = 4'($urandom_range(1, 15));
				if (hi <= crld_pkg::MAX_FIELD_BYTES && lo <= crld_pkg::MAX_FIELD_BYTES) begin
					if ($urandom_range(1))
						hi = 4'($urandom_range(9, 15));
					else
						lo = 4'($urandom_range(9, 15));
				end
				push_byte({hi, lo}, 1'($urandom));
				if (!list_bytes[list_bytes.size() - 1].fin)
					close_list();
			end
			default: begin
				repeat ($urandom_range(1, 6))
					push_byte(8'($urandom), ($urandom_range(7) == 0));
				close_list();
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Output side: random stall, compare against the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk)
		result_stall <= ($urandom_range(99) < receiver_stall_pct);

	always @(posedge clk) begin : check_results
		run_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (run_present)
				runs_seen++;
			if (list_end)
				ends_seen[end_status]++;
			if (awaited_results.size() == 0) begin
				$error("result item with none expected (run_present %0b, list_end %0b)",
					run_present, list_end);
				fail_count++;
			end else begin
				want = awaited_results.pop_front();
				if (run_present !== want.present) begin
					$error("run_present: expected %0b, got %0b", want.present, run_present);
					fail_count++;
				end
				if (run_start_cluster !== want.start_cluster) begin
					$error("run_start_cluster: expected %0h, got %0h",
						want.start_cluster, run_start_cluster);
					fail_count++;
				end
				if (run_length !== want.length) begin
					$error("run_length: expected %0h, got %0h", want.length, run_length);
					fail_count++;
				end
				if (list_end !== want.list_end) begin
					$error("list_end: expected %0b, got %0b", want.list_end, list_end);
					fail_count++;
				end
				if (end_status !== want.status) begin
					$error("end_status: expected %0d, got %0d", want.status, end_status);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		list_byte_t next;

		arst_n             = 1'b0;
		byte_valid         = 1'b0;
		data_byte          = '0;
		final_byte         = 1'b0;
		sender_idle_pct    = 25;
		receiver_stall_pct = 59;
		fail_count         = 0;
		cycle_count        = 0;
		decoded_bytes      = 0;
		ignored_bytes      = 0;
		runs_seen          = 0;
		foreach (ends_seen[i])
			ends_seen[i] = 0;
		clear_decoder();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_byte(directed_rows[i].data, directed_rows[i].fin,
				directed_rows[i].mode, directed_rows[i].want);

		// random lists; idle mix changes by thirds
		while (decoded_bytes + ignored_bytes < TARGET_BYTES) begin
			if (decoded_bytes + ignored_bytes >= 2 * TARGET_BYTES / 3) begin
				sender_idle_pct    = 0;
				receiver_stall_pct = 0;
			end else if (decoded_bytes + ignored_bytes >= TARGET_BYTES / 3) begin
				sender_idle_pct    = 59;
				receiver_stall_pct = 25;
			end
			build_list();
			while (list_bytes.size() != 0) begin
				next = list_bytes.pop_front();
				send_byte(next.data, next.fin, BY_MODEL, NO_RESULT);
			end
		end
		byte_valid <= 1'b0;
		receiver_stall_pct = 0;

		// drain, then keep watching for stray items
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d bytes (%0d decoded, %0d dropped after an error end)",
			decoded_bytes + ignored_bytes, decoded_bytes, ignored_bytes);
		$display("Saw %0d runs; list ends clean/term/zero-len/trunc/oversize: %0d/%0d/%0d/%0d/%0d",
			runs_seen, ends_seen[crld_pkg::ST_RUNNING], ends_seen[crld_pkg::ST_TERMINATOR],
			ends_seen[crld_pkg::ST_ZERO_LENGTH], ends_seen[crld_pkg::ST_TRUNCATED],
			ends_seen[crld_pkg::ST_OVERSIZE]);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/crld_pkg.sv
rtl/core/crld_front.sv
rtl/core/crld_queue.sv
rtl/core/crld_back.sv
rtl/core/cluster_run_list_decoder_top.sv
dv/cluster_run_list_decoder_top_test.sv
